### hdl/alse_pkg.sv
// ----------------------------------------------------------------------------
// alse_pkg: shared definitions for the array list shift engine
// Sizes, operation and status codes, and the command word that is broadcast
// to every storage cell of the chain.
// ----------------------------------------------------------------------------
package alse_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;

	// Field widths fixed by the word formats.
	localparam int FUNC_W   = 3;
	localparam int POS_W    = 5;
	localparam int CNT_W    = 5;
	localparam int STAT_W   = 2;
	localparam int IDX_W    = $clog2(CAPACITY);

	localparam int IN_BITS  = FUNC_W + POS_W + DATA_WIDTH;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = DATA_WIDTH + POS_W + CNT_W + 1 + STAT_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// Operation codes.
	localparam logic [FUNC_W-1:0] OP_APPEND = 3'd0;
	localparam logic [FUNC_W-1:0] OP_INSERT = 3'd1;
	localparam logic [FUNC_W-1:0] OP_REMOVE = 3'd2;
	localparam logic [FUNC_W-1:0] OP_READ   = 3'd3;
	localparam logic [FUNC_W-1:0] OP_FIND   = 3'd4;
	localparam logic [FUNC_W-1:0] OP_CLEAR  = 3'd5;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	localparam logic [POS_W-1:0] NOT_FOUND = '1;
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);

	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [POS_W-1:0]      pos_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	// Command broadcast to all cells in the cycle a word is accepted.
	typedef struct packed {
		logic  append_en;
		logic  insert_en;
		logic  remove_en;
		pos_t  idx;
		cnt_t  count;
		data_t data;
	} cell_cmd_t;

endpackage

### hdl/alse_cell.sv
// ----------------------------------------------------------------------------
// alse_cell: one storage cell of the list chain
// Holds one entry, takes a new value, its lower or its upper neighbor's entry
// as the broadcast command asks, and flags a match for the find operation.
// ----------------------------------------------------------------------------
module alse_cell (
	input  logic                 clk,
	input  alse_pkg::pos_t       cell_idx,
	input  alse_pkg::cell_cmd_t  cmd,
	input  alse_pkg::data_t      lower_entry,
	input  alse_pkg::data_t      upper_entry,
	output alse_pkg::data_t      entry,
	output logic                 hit
);

	alse_pkg::data_t entry_q;
	logic            held;

	assign held  = ({1'b0, cell_idx} < {1'b0, cmd.count});
	assign hit   = held && (entry_q == cmd.data);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		priority if (cmd.append_en && cell_idx == cmd.count) begin
			entry_q <= cmd.data;
		end else if (cmd.insert_en && cell_idx == cmd.idx) begin
			entry_q <= cmd.data;
		end else if (cmd.insert_en && cell_idx > cmd.idx && cell_idx <= cmd.count) begin
			entry_q <= lower_entry;
		end else if (cmd.remove_en && cell_idx >= cmd.idx) begin
			entry_q <= upper_entry;
		end else begin
			entry_q <= entry_q;
		end
	end

endmodule

### hdl/array_list_shift_engine.sv
// ----------------------------------------------------------------------------
// array_list_shift_engine: bounded ordered list in a chain of cells
// Append, indexed insert and remove with shifting, indexed read, find and
// clear, one result word for every operation word.
// ----------------------------------------------------------------------------
// The list lives in a row of sixteen cells, one entry each. Every accepted
// word is carried out in the cycle it is accepted: on an insert every cell
// above the index, up to the count, takes its lower neighbor's entry while the
// addressed cell takes the new value, on a remove every cell from the index up
// takes its upper neighbor's entry, and on a find every cell compares its
// entry against the searched value at once, with a priority encoder picking
// the lowest hit.
// The result word appears in the cycle after acceptance in an output register,
// and a new word is taken every cycle as long as that register is free or is
// being drained in the same cycle, so the sustained rate is one word per
// clock. A full list or an index out of range is reported in the status field
// and leaves the list untouched; the count and empty flag always describe the
// list after the operation. Entries are not cleared by reset or by the clear
// operation, since only entries below the count are ever read.
module array_list_shift_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// From bit 0: func[2:0], position_in[7:3], data_in[39:8].
	input  logic [alse_pkg::IN_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// From bit 0: data_out[31:0], found_position[36:32], count_out[41:37],
	// empty_flag[42], status[44:43], zero fill above.
	output logic [alse_pkg::OUT_W-1:0] m_tdata
);

	localparam int POS_LO  = alse_pkg::FUNC_W;
	localparam int DATA_LO = alse_pkg::FUNC_W + alse_pkg::POS_W;

	// Unpacked input fields.
	logic [alse_pkg::FUNC_W-1:0] func;
	alse_pkg::pos_t              position_in;
	alse_pkg::data_t             data_in;

	assign func        = s_tdata[alse_pkg::FUNC_W-1:0];
	assign position_in = s_tdata[POS_LO +: alse_pkg::POS_W];
	assign data_in     = s_tdata[DATA_LO +: alse_pkg::DATA_WIDTH];

	logic accept;
	assign s_tready = !m_tvalid || m_tready;
	assign accept   = s_tvalid && s_tready;

	alse_pkg::cnt_t count_q;

	// Cell chain.
	alse_pkg::data_t     entries [alse_pkg::CAPACITY];
	logic [alse_pkg::CAPACITY-1:0] hits;
	alse_pkg::cell_cmd_t cmd;

	for (genvar i = 0; i < alse_pkg::CAPACITY; i++) begin : g_cell
		alse_pkg::data_t lower_entry;
		alse_pkg::data_t upper_entry;

		if (i == 0) begin : g_first
			assign lower_entry = '0;
		end else begin : g_lower
			assign lower_entry = entries[i-1];
		end

		if (i == alse_pkg::CAPACITY - 1) begin : g_last
			assign upper_entry = '0;
		end else begin : g_upper
			assign upper_entry = entries[i+1];
		end

		alse_cell u_cell (
			.clk        (clk),
			.cell_idx   (alse_pkg::POS_W'(i)),
			.cmd        (cmd),
			.lower_entry(lower_entry),
			.upper_entry(upper_entry),
			.entry      (entries[i]),
			.hit        (hits[i])
		);
	end

	// The lowest matching cell wins. Cells at or above the count never hit.
	alse_pkg::pos_t first_hit;
	always_comb begin
		first_hit = alse_pkg::NOT_FOUND;
		for (int k = alse_pkg::CAPACITY - 1; k >= 0; k--) begin
			if (hits[k]) begin
				first_hit = alse_pkg::POS_W'(k);
			end
		end
	end

	// Indexed read. Only used when the index is below the count.
	alse_pkg::data_t picked;
	assign picked = entries[position_in[alse_pkg::IDX_W-1:0]];

	// Operation decode.
	logic                        is_full;
	logic                        idx_below;
	logic                        idx_upto;
	logic                        do_append;
	logic                        do_insert;
	logic                        do_remove;
	alse_pkg::cnt_t              next_count;
	alse_pkg::data_t             res_data;
	alse_pkg::pos_t              res_pos;
	logic [alse_pkg::STAT_W-1:0] res_status;

	assign is_full   = (count_q == alse_pkg::FULL_CNT);
	assign idx_below = (position_in < count_q);
	assign idx_upto  = (position_in <= count_q);

	always_comb begin
		do_append  = 1'b0;
		do_insert  = 1'b0;
		do_remove  = 1'b0;
		next_count = count_q;
		res_data   = '0;
		res_pos    = alse_pkg::NOT_FOUND;
		res_status = alse_pkg::ST_OK;
		unique case (func)
			alse_pkg::OP_APPEND: begin
				if (is_full) begin
					res_status = alse_pkg::ST_FULL;
				end else begin
					do_append  = 1'b1;
					next_count = count_q + alse_pkg::cnt_t'(1);
				end
			end
			alse_pkg::OP_INSERT: begin
				if (is_full) begin
					res_status = alse_pkg::ST_FULL;
				end else if (!idx_upto) begin
					res_status = alse_pkg::ST_RANGE;
				end else begin
					do_insert  = 1'b1;
					next_count = count_q + alse_pkg::cnt_t'(1);
				end
			end
			alse_pkg::OP_REMOVE: begin
				if (!idx_below) begin
					res_status = alse_pkg::ST_RANGE;
				end else begin
					do_remove  = 1'b1;
					res_data   = picked;
					next_count = count_q - alse_pkg::cnt_t'(1);
				end
			end
			alse_pkg::OP_READ: begin
				if (!idx_below) begin
					res_status = alse_pkg::ST_RANGE;
				end else begin
					res_data = picked;
				end
			end
			alse_pkg::OP_FIND: begin
				res_pos = first_hit;
			end
			alse_pkg::OP_CLEAR: begin
				next_count = '0;
			end
			default: begin
				// Unused codes leave the list alone.
			end
		endcase
	end

	always_comb begin
		cmd.append_en = accept && do_append;
		cmd.insert_en = accept && do_insert;
		cmd.remove_en = accept && do_remove;
		cmd.idx       = position_in;
		cmd.count     = count_q;
		cmd.data      = data_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= next_count;
			end
			if (accept) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// Result word, held until the downstream side takes it.
	logic [alse_pkg::OUT_W-1:0] out_q;
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= alse_pkg::OUT_W'({res_status, (next_count == '0), next_count,
				res_pos, res_data});
		end
	end

	assign m_tdata = out_q;

endmodule
